[hdl/assert_macros.svh]
// assertion helpers for the quaternion exponential map
// expects signals named clock and reset in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define QEXP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

`define QEXP_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

[hdl/qexp_pkg.sv]
// shared types, widths and constants for the quaternion exponential map
// no dependencies
`timescale 1ns / 1ps
package qexp_pkg;

   localparam int DATA_WIDTH        = 16;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int IN_FRAC           = DATA_WIDTH - 4;
   localparam int ANG_FRAC          = 28;
   localparam int SUM_W             = 2 * DATA_WIDTH + 2;
   localparam int THETA_W           = DATA_WIDTH + 1;
   localparam int XY_W              = 34;
   localparam int Z_W               = 33;
   localparam int QUO_W             = 16;
   localparam int OUT_W             = 16;
   localparam int ROUND_SH          = 16;
   localparam int MAG_W             = XY_W + DATA_WIDTH;
   localparam int NUM_W             = MAG_W + 1;
   localparam int NH_W              = NUM_W - ROUND_SH;

   localparam logic signed [OUT_W-1:0] Q_ONE = 16'sd16384;
   localparam logic signed [OUT_W-1:0] Q_MIN = -16'sd16384;

   localparam logic signed [XY_W-1:0] GAIN_Q30    = 34'sd652032874;
   localparam logic signed [Z_W-1:0]  PI_Q28      = 33'sd843314857;
   localparam logic signed [Z_W-1:0]  HALF_PI_Q28 = 33'sd421657428;
   localparam logic signed [Z_W-1:0]  TWO_PI_Q28  = 33'sd1686629713;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] rot_x;
      logic signed [DATA_WIDTH-1:0] rot_y;
      logic signed [DATA_WIDTH-1:0] rot_z;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] quat_w;
      logic signed [OUT_W-1:0] quat_x;
      logic signed [OUT_W-1:0] quat_y;
      logic signed [OUT_W-1:0] quat_z;
   } rsp_type;

   // angle results handed from the cordic to the scaling pipeline
   typedef struct packed {
      logic                    zero;
      logic                    s_neg;
      logic [XY_W-1:0]         s_mag;
      logic signed [OUT_W-1:0] w;
      logic [THETA_W-1:0]      theta;
   } ang_type;

   function automatic logic signed [Z_W-1:0] atan_q28(input int unsigned idx);
      logic signed [Z_W-1:0] r;
      case (idx)
         0:  r = 33'sd210828714;
         1:  r = 33'sd124459457;
         2:  r = 33'sd65760959;
         3:  r = 33'sd33381290;
         4:  r = 33'sd16755422;
         5:  r = 33'sd8385879;
         6:  r = 33'sd4193963;
         7:  r = 33'sd2097109;
         8:  r = 33'sd1048571;
         9:  r = 33'sd524287;
         10: r = 33'sd262144;
         11: r = 33'sd131072;
         12: r = 33'sd65536;
         13: r = 33'sd32768;
         14: r = 33'sd16384;
         15: r = 33'sd8192;
         16: r = 33'sd4096;
         17: r = 33'sd2048;
         18: r = 33'sd1024;
         19: r = 33'sd512;
         20: r = 33'sd256;
         21: r = 33'sd128;
         22: r = 33'sd64;
         23: r = 33'sd32;
         24: r = 33'sd16;
         25: r = 33'sd8;
         26: r = 33'sd4;
         27: r = 33'sd2;
         28: r = 33'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

[hdl/quaternion_exponential_map.sv]
// top level of the quaternion exponential map
// depends on qexp_pkg, qexp_norm, qexp_cordic, qexp_scale
`timescale 1ns / 1ps

// Takes one rotation vector per clock (start high, busy is always low) and
// returns the unit quaternion on rsp_data with rsp_valid high for one cycle.
// The square root gives one bit per stage, the cordic one micro-rotation
// per stage and the divider one quotient bit per stage, which sets the
// pipeline depth. The receiver cannot stall, so every accepted beat yields
// exactly one result beat in order.
module quaternion_exponential_map import qexp_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int LATENCY = (THETA_W + 2) + (CORDIC_STAGES + 3) + (QUO_W + 3);

   logic               norm_valid, cor_valid;
   logic [THETA_W-1:0] norm_theta;
   req_type            norm_vec, cor_vec;
   ang_type            cor_ang;
   logic               req_beat;

   assign busy     = 1'b0;
   assign req_beat = start && !busy;

   qexp_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_beat),
      .in_vec    (req_data),
      .out_valid (norm_valid),
      .out_theta (norm_theta),
      .out_vec   (norm_vec)
   );

   qexp_cordic #(
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (norm_valid),
      .in_theta  (norm_theta),
      .in_vec    (norm_vec),
      .out_valid (cor_valid),
      .out_ang   (cor_ang),
      .out_vec   (cor_vec)
   );

   qexp_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cor_valid),
      .in_ang    (cor_ang),
      .in_vec    (cor_vec),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

   `include "assert_macros.svh"
   `QEXP_ASSERT_IMPL(a_rsp_lat, rsp_valid, $past(start, LATENCY), "result beat without matching start")
   `QEXP_ASSERT_IMPL(a_w_range, rsp_valid, (rsp_data.quat_w <= Q_ONE) && (rsp_data.quat_w >= Q_MIN), "scalar part out of range")
   `QEXP_ASSERT_IMPL(a_x_range, rsp_valid, (rsp_data.quat_x <= Q_ONE) && (rsp_data.quat_x >= Q_MIN), "x part out of range")

endmodule

[hdl/qexp_norm.sv]
// vector norm: squares, sum and a bit-per-stage square root pipeline
// depends on qexp_pkg
`timescale 1ns / 1ps
module qexp_norm import qexp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  req_type            in_vec,
   output logic               out_valid,
   output logic [THETA_W-1:0] out_theta,
   output req_type            out_vec
);

   localparam int LATENCY = THETA_W + 2;
   localparam int CW      = SUM_W + 2;

   logic [DATA_WIDTH-1:0]   abs_x, abs_y, abs_z;
   logic [2*DATA_WIDTH-1:0] sqx_ff, sqy_ff, sqz_ff;
   logic                    sq_valid_ff;
   req_type                 sq_vec_ff;

   logic [SUM_W-1:0]   rem_ff   [0:THETA_W];
   logic [THETA_W-1:0] root_ff  [0:THETA_W];
   logic               valid_ff [0:THETA_W];
   req_type            vec_ff   [0:THETA_W];

   assign abs_x = in_vec.rot_x[DATA_WIDTH-1] ? (~in_vec.rot_x + 1'b1) : in_vec.rot_x;
   assign abs_y = in_vec.rot_y[DATA_WIDTH-1] ? (~in_vec.rot_y + 1'b1) : in_vec.rot_y;
   assign abs_z = in_vec.rot_z[DATA_WIDTH-1] ? (~in_vec.rot_z + 1'b1) : in_vec.rot_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         valid_ff[0] <= 1'b0;
      end else begin
         sq_valid_ff <= in_valid;
         valid_ff[0] <= sq_valid_ff;
      end
      sqx_ff    <= abs_x * abs_x;
      sqy_ff    <= abs_y * abs_y;
      sqz_ff    <= abs_z * abs_z;
      sq_vec_ff <= in_vec;
      rem_ff[0]  <= SUM_W'(sqx_ff) + SUM_W'(sqy_ff) + SUM_W'(sqz_ff);
      root_ff[0] <= '0;
      vec_ff[0]  <= sq_vec_ff;
   end

   // one root bit per stage, most significant first
   for (genvar g = 0; g < THETA_W; g++) begin : g_sqrt
      localparam int B = THETA_W - 1 - g;
      logic [CW-1:0]      cand;
      logic [SUM_W-1:0]   rem_in;
      logic [THETA_W-1:0] root_in;

      always_comb begin
         cand    = (CW'(root_ff[g]) << (B + 1)) + (CW'(1) << (2 * B));
         rem_in  = rem_ff[g];
         root_in = root_ff[g];
         if (CW'(rem_ff[g]) >= cand) begin
            rem_in  = rem_ff[g] - cand[SUM_W-1:0];
            root_in = root_ff[g] | (THETA_W'(1) << B);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g+1] <= 1'b0;
         end else begin
            valid_ff[g+1] <= valid_ff[g];
         end
         rem_ff[g+1]  <= rem_in;
         root_ff[g+1] <= root_in;
         vec_ff[g+1]  <= vec_ff[g];
      end
   end

   assign out_valid = valid_ff[THETA_W];
   assign out_theta = root_ff[THETA_W];
   assign out_vec   = vec_ff[THETA_W];

   `include "assert_macros.svh"
   `QEXP_ASSERT_IMPL(a_norm_lat, out_valid, $past(in_valid, LATENCY), "norm beat without input")

endmodule

[hdl/qexp_cordic.sv]
// half-angle folding and rotation-mode cordic, one micro-rotation per stage
// depends on qexp_pkg
`timescale 1ns / 1ps
module qexp_cordic import qexp_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [THETA_W-1:0] in_theta,
   input  req_type            in_vec,
   output logic               out_valid,
   output ang_type            out_ang,
   output req_type            out_vec
);

   localparam int SH = ANG_FRAC - IN_FRAC;

   logic [Z_W-1:0]        phi_full;
   logic signed [Z_W-1:0] phi_a, phi_b;
   logic                  nb_b, nc_b;

   logic                  a_valid_ff, a_zero_ff;
   logic signed [Z_W-1:0] a_phi_ff;
   logic [THETA_W-1:0]    a_theta_ff;
   req_type               a_vec_ff;

   logic signed [XY_W-1:0] x_ff     [0:CORDIC_STAGES];
   logic signed [XY_W-1:0] y_ff     [0:CORDIC_STAGES];
   logic signed [Z_W-1:0]  z_ff     [0:CORDIC_STAGES];
   logic                   valid_ff [0:CORDIC_STAGES];
   logic                   zero_ff  [0:CORDIC_STAGES];
   logic                   nb_ff    [0:CORDIC_STAGES];
   logic                   nc_ff    [0:CORDIC_STAGES];
   logic [THETA_W-1:0]     theta_ff [0:CORDIC_STAGES];
   req_type                vec_ff   [0:CORDIC_STAGES];

   logic                   f_valid_ff;
   ang_type                f_ang_ff;
   req_type                f_vec_ff;

   // fold stage one: half angle, then one wrap by two pi
   always_comb begin
      phi_full = (Z_W'(in_theta) << SH) >> 1;
      phi_a    = $signed(phi_full);
      if (phi_a >= TWO_PI_Q28) begin
         phi_a = phi_a - TWO_PI_Q28;
      end
   end

   // fold stage two: into [0, pi) then mirror into [0, pi/2]
   always_comb begin
      phi_b = a_phi_ff;
      nb_b  = 1'b0;
      nc_b  = 1'b0;
      if (phi_b >= PI_Q28) begin
         phi_b = phi_b - PI_Q28;
         nb_b  = 1'b1;
      end
      if (phi_b > HALF_PI_Q28) begin
         phi_b = PI_Q28 - phi_b;
         nc_b  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff  <= 1'b0;
         valid_ff[0] <= 1'b0;
      end else begin
         a_valid_ff  <= in_valid;
         valid_ff[0] <= a_valid_ff;
      end
      a_phi_ff    <= phi_a;
      a_zero_ff   <= (in_theta == '0);
      a_theta_ff  <= in_theta;
      a_vec_ff    <= in_vec;
      x_ff[0]     <= GAIN_Q30;
      y_ff[0]     <= '0;
      z_ff[0]     <= phi_b;
      zero_ff[0]  <= a_zero_ff;
      nb_ff[0]    <= nb_b;
      nc_ff[0]    <= nc_b;
      theta_ff[0] <= a_theta_ff;
      vec_ff[0]   <= a_vec_ff;
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
      logic signed [XY_W-1:0] dx, dy, x_in, y_in;
      logic signed [Z_W-1:0]  z_in;

      always_comb begin
         dx = y_ff[i] >>> i;
         dy = x_ff[i] >>> i;
         if (!z_ff[i][Z_W-1]) begin
            x_in = x_ff[i] - dx;
            y_in = y_ff[i] + dy;
            z_in = z_ff[i] - atan_q28(i);
         end else begin
            x_in = x_ff[i] + dx;
            y_in = y_ff[i] - dy;
            z_in = z_ff[i] + atan_q28(i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else begin
            valid_ff[i+1] <= valid_ff[i];
         end
         x_ff[i+1]     <= x_in;
         y_ff[i+1]     <= y_in;
         z_ff[i+1]     <= z_in;
         zero_ff[i+1]  <= zero_ff[i];
         nb_ff[i+1]    <= nb_ff[i];
         nc_ff[i+1]    <= nc_ff[i];
         theta_ff[i+1] <= theta_ff[i];
         vec_ff[i+1]   <= vec_ff[i];
      end
   end

   // quadrant fixup, rounding and clamping of the scalar part, sine magnitude and sign
   logic signed [XY_W-1:0] c_fix, s_fix, c_rnd;
   ang_type                f_ang_in;

   always_comb begin
      c_fix = (nb_ff[CORDIC_STAGES] ^ nc_ff[CORDIC_STAGES]) ?
              -x_ff[CORDIC_STAGES] : x_ff[CORDIC_STAGES];
      s_fix = nb_ff[CORDIC_STAGES] ? -y_ff[CORDIC_STAGES] : y_ff[CORDIC_STAGES];
      c_rnd = (c_fix + (XY_W'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
      f_ang_in.zero  = zero_ff[CORDIC_STAGES];
      f_ang_in.theta = theta_ff[CORDIC_STAGES];
      f_ang_in.s_neg = s_fix[XY_W-1];
      f_ang_in.s_mag = s_fix[XY_W-1] ? XY_W'(-s_fix) : XY_W'(s_fix);
      if (zero_ff[CORDIC_STAGES]) begin
         f_ang_in.w = Q_ONE;
      end else if (c_rnd > XY_W'(Q_ONE)) begin
         f_ang_in.w = Q_ONE;
      end else if (c_rnd < XY_W'(Q_MIN)) begin
         f_ang_in.w = Q_MIN;
      end else begin
         f_ang_in.w = c_rnd[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= valid_ff[CORDIC_STAGES];
      end
      f_ang_ff <= f_ang_in;
      f_vec_ff <= vec_ff[CORDIC_STAGES];
   end

   assign out_valid = f_valid_ff;
   assign out_ang   = f_ang_ff;
   assign out_vec   = f_vec_ff;

   `include "assert_macros.svh"
   `QEXP_ASSERT_IMPL(a_fold_range, valid_ff[0], (z_ff[0] >= 0) && (z_ff[0] <= HALF_PI_Q28), "folded angle out of range")

endmodule

[hdl/qexp_scale.sv]
// vector part: sine times component, rounded division by theta, saturation
// depends on qexp_pkg
`timescale 1ns / 1ps
module qexp_scale import qexp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  ang_type in_ang,
   input  req_type in_vec,
   output logic    out_valid,
   output rsp_type out_rsp
);

   localparam int CMP_W = NH_W + 2;

   logic [DATA_WIDTH-1:0] abs_v [0:2];
   logic                  neg_v [0:2];

   logic                  m_valid_ff;
   ang_type               m_ang_ff;
   logic [MAG_W-1:0]      m_mag_ff  [0:2];
   logic                  m_sign_ff [0:2];

   logic [NUM_W-1:0]      num     [0:2];
   logic [NH_W-1:0]       rem_ff  [0:2][0:QUO_W];
   logic [QUO_W-1:0]      quo_ff  [0:2][0:QUO_W];
   logic                  ovf_ff  [0:2][0:QUO_W];
   logic                  sign_ff [0:2][0:QUO_W];
   logic                  valid_ff [0:QUO_W];
   ang_type               ang_ff   [0:QUO_W];

   logic                  o_valid_ff;
   rsp_type               o_rsp_ff;

   always_comb begin
      abs_v[0] = in_vec.rot_x[DATA_WIDTH-1] ? (~in_vec.rot_x + 1'b1) : in_vec.rot_x;
      abs_v[1] = in_vec.rot_y[DATA_WIDTH-1] ? (~in_vec.rot_y + 1'b1) : in_vec.rot_y;
      abs_v[2] = in_vec.rot_z[DATA_WIDTH-1] ? (~in_vec.rot_z + 1'b1) : in_vec.rot_z;
      neg_v[0] = in_vec.rot_x[DATA_WIDTH-1];
      neg_v[1] = in_vec.rot_y[DATA_WIDTH-1];
      neg_v[2] = in_vec.rot_z[DATA_WIDTH-1];
   end

   // add half the divisor, then drop the low bits that the divisor's 2^16 covers
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         num[k] = NUM_W'(m_mag_ff[k]) + (NUM_W'(m_ang_ff.theta) << (ROUND_SH - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff  <= 1'b0;
         valid_ff[0] <= 1'b0;
      end else begin
         m_valid_ff  <= in_valid;
         valid_ff[0] <= m_valid_ff;
      end
      m_ang_ff  <= in_ang;
      ang_ff[0] <= m_ang_ff;
      for (int k = 0; k < 3; k++) begin
         m_mag_ff[k]  <= MAG_W'(in_ang.s_mag) * MAG_W'(abs_v[k]);
         m_sign_ff[k] <= in_ang.s_neg ^ neg_v[k];
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_lane
      always_ff @(posedge clock) begin
         rem_ff[k][0]  <= num[k][NUM_W-1:ROUND_SH];
         quo_ff[k][0]  <= '0;
         sign_ff[k][0] <= m_sign_ff[k];
         ovf_ff[k][0]  <= CMP_W'(num[k][NUM_W-1:ROUND_SH]) >=
                          (CMP_W'(m_ang_ff.theta) << QUO_W);
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar g = 0; g < QUO_W; g++) begin : g_div
      localparam int J = QUO_W - 1 - g;
      logic [NH_W-1:0]  rem_in [0:2];
      logic [QUO_W-1:0] quo_in [0:2];
      logic [CMP_W-1:0] dsh;

      always_comb begin
         dsh = CMP_W'(ang_ff[g].theta) << J;
         for (int k = 0; k < 3; k++) begin
            rem_in[k] = rem_ff[k][g];
            quo_in[k] = quo_ff[k][g];
            if (CMP_W'(rem_ff[k][g]) >= dsh) begin
               rem_in[k] = rem_ff[k][g] - dsh[NH_W-1:0];
               quo_in[k] = quo_ff[k][g] | (QUO_W'(1) << J);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g+1] <= 1'b0;
         end else begin
            valid_ff[g+1] <= valid_ff[g];
         end
         ang_ff[g+1] <= ang_ff[g];
      end

      for (genvar k = 0; k < 3; k++) begin : g_lane
         always_ff @(posedge clock) begin
            rem_ff[k][g+1]  <= rem_in[k];
            quo_ff[k][g+1]  <= quo_in[k];
            ovf_ff[k][g+1]  <= ovf_ff[k][g];
            sign_ff[k][g+1] <= sign_ff[k][g];
         end
      end
   end

   logic signed [OUT_W-1:0] q_sat [0:2];
   logic signed [OUT_W-1:0] q_out [0:2];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (ovf_ff[k][QUO_W] || (quo_ff[k][QUO_W] > QUO_W'(Q_ONE))) begin
            q_sat[k] = Q_ONE;
         end else begin
            q_sat[k] = $signed(OUT_W'(quo_ff[k][QUO_W]));
         end
         if (ang_ff[QUO_W].zero) begin
            q_out[k] = '0;
         end else begin
            q_out[k] = sign_ff[k][QUO_W] ? -q_sat[k] : q_sat[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else begin
         o_valid_ff <= valid_ff[QUO_W];
      end
      o_rsp_ff.quat_w <= ang_ff[QUO_W].w;
      o_rsp_ff.quat_x <= q_out[0];
      o_rsp_ff.quat_y <= q_out[1];
      o_rsp_ff.quat_z <= q_out[2];
   end

   assign out_valid = o_valid_ff;
   assign out_rsp   = o_rsp_ff;

   logic zero_beat, vec_is_zero;
   assign zero_beat   = o_valid_ff && (o_rsp_ff.quat_w == Q_ONE);
   assign vec_is_zero = (o_rsp_ff.quat_x == 0) && (o_rsp_ff.quat_y == 0) &&
                        (o_rsp_ff.quat_z == 0);

   `include "assert_macros.svh"
   `QEXP_ASSERT_IMPL(a_zero_vec, zero_beat && $past(ang_ff[QUO_W].zero), vec_is_zero, "zero angle")

endmodule

[dv/quaternion_exponential_map_tb.sv]
// self-checking testbench for the quaternion exponential map
// depends on qexp_pkg and quaternion_exponential_map
`timescale 1ns / 1ps

module quaternion_exponential_map_tb;
   import qexp_pkg::*;

   localparam int LATENCY     = 57;
   localparam int RANDOM_BEATS = 850;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      req_type req;
      logic    known;
      rsp_type rsp;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   rsp_type quat_queue[$];
   int      error_count;
   int      cycle_count;

   quaternion_exponential_map dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic longint floor_shift(longint v, int s);
      if (v >= 0) return v >>> s;
      return -(((-v) - 1) >>> s) - 1;
   endfunction

   function automatic longint clamp_q14(longint v);
      if (v > 16384) return 16384;
      if (v < -16384) return -16384;
      return v;
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned res, bit_val;
      res = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > v) bit_val >>= 2;
      while (bit_val != 0) begin
         if (v >= res + bit_val) begin
            v -= res + bit_val;
            res = (res >> 1) + bit_val;
         end else begin
            res >>= 1;
         end
         bit_val >>= 2;
      end
      return res;
   endfunction

   function automatic rsp_type exp_map(req_type r);
      longint comp[3];
      longint unsigned sum, theta, den, mag;
      longint phi, zang, cx, cy, dx, dy, num, q;
      logic neg_both, neg_cos;
      longint quat[3];
      rsp_type o;
      comp[0] = r.rot_x;
      comp[1] = r.rot_y;
      comp[2] = r.rot_z;
      sum = 0;
      neg_both = 0;
      neg_cos = 0;
      for (int k = 0; k < 3; k++) sum += comp[k] * comp[k];
      theta = int_sqrt(sum);
      if (theta == 0) begin
         o.quat_w = Q_ONE;
         o.quat_x = '0;
         o.quat_y = '0;
         o.quat_z = '0;
         return o;
      end
      phi = longint'((theta << (ANG_FRAC - IN_FRAC)) >> 1);
      if (phi >= longint'(TWO_PI_Q28)) phi -= longint'(TWO_PI_Q28);
      if (phi >= longint'(PI_Q28)) begin
         phi -= longint'(PI_Q28);
         neg_both = 1;
      end
      if (phi > longint'(HALF_PI_Q28)) begin
         phi = longint'(PI_Q28) - phi;
         neg_cos = 1;
      end
      cx = longint'(GAIN_Q30);
      cy = 0;
      zang = phi;
      for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
         dx = floor_shift(cy, i);
         dy = floor_shift(cx, i);
         if (zang >= 0) begin
            cx -= dx;
            cy += dy;
            zang -= longint'(atan_q28(i));
         end else begin
            cx += dx;
            cy -= dy;
            zang += longint'(atan_q28(i));
         end
      end
      if (neg_both) begin
         cx = -cx;
         cy = -cy;
      end
      if (neg_cos) cx = -cx;
      o.quat_w = 16'(clamp_q14(floor_shift(cx + (64'sd1 <<< 15), 16)));
      den = theta << 16;
      for (int k = 0; k < 3; k++) begin
         num = cy * comp[k];
         mag = (num < 0) ? -num : num;
         q = longint'((mag + (den >> 1)) / den);
         if (num < 0) q = -q;
         quat[k] = clamp_q14(q);
      end
      o.quat_x = 16'(quat[0]);
      o.quat_y = 16'(quat[1]);
      o.quat_z = 16'(quat[2]);
      return o;
   endfunction

   // drive one beat and wait for its accept; start stays high for a following beat
   task automatic send_beat(req_type r, rsp_type expected);
      req_data <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      quat_queue.push_back(expected);
      @(negedge clock);
   endtask

   task automatic idle_burst(int pct);
      if ($urandom_range(99) < pct) begin
         start <= 1'b0;
         repeat ($urandom_range(13, 1)) @(negedge clock);
      end
   endtask

   function automatic req_type rand_vec(int mode);
      req_type r;
      case (mode)
         0: r = {16'($urandom), 16'($urandom), 16'($urandom)};
         1: r = {16'($signed($urandom_range(8191)) - 4096),
                 16'($signed($urandom_range(8191)) - 4096),
                 16'($signed($urandom_range(8191)) - 4096)};
         2: r = {16'($signed($urandom_range(15)) - 8), 16'($signed($urandom_range(15)) - 8),
                 16'($signed($urandom_range(15)) - 8)};
         default: begin
            r = '0;
            case ($urandom_range(2))
               0: r.rot_x = 16'($urandom);
               1: r.rot_y = 16'($urandom);
               default: r.rot_z = 16'($urandom);
            endcase
         end
      endcase
      return r;
   endfunction

   // checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (quat_queue.size() == 0) begin
            $error("result beat with nothing expected: %h", rsp_data);
            error_count++;
         end else begin
            rsp_type e;
            e = quat_queue.pop_front();
            if (rsp_data.quat_w !== e.quat_w) begin
               $error("quat_w expected %0d actual %0d", e.quat_w, rsp_data.quat_w);
               error_count++;
            end
            if (rsp_data.quat_x !== e.quat_x) begin
               $error("quat_x expected %0d actual %0d", e.quat_x, rsp_data.quat_x);
               error_count++;
            end
            if (rsp_data.quat_y !== e.quat_y) begin
               $error("quat_y expected %0d actual %0d", e.quat_y, rsp_data.quat_y);
               error_count++;
            end
            if (rsp_data.quat_z !== e.quat_z) begin
               $error("quat_z expected %0d actual %0d", e.quat_z, rsp_data.quat_z);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      int wait_count;
      error_count = 0;
      cycle_count = 0;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      // zero angle gives the identity; others come from the predictor
      rows.push_back('{'{16'sd0, 16'sd0, 16'sd0}, 1'b1, '{Q_ONE, 16'sd0, 16'sd0, 16'sd0}});
      rows.push_back('{'{16'sd1, 16'sd0, 16'sd0}, 1'b0, '0});
      rows.push_back('{'{-16'sd1, 16'sd0, 16'sd0}, 1'b0, '0});
      rows.push_back('{'{16'sd0, 16'sd1, -16'sd1}, 1'b0, '0});
      rows.push_back('{'{16'sd32767, 16'sd0, 16'sd0}, 1'b0, '0});
      rows.push_back('{'{-16'sd32768, 16'sd0, 16'sd0}, 1'b0, '0});
      rows.push_back('{'{16'sd0, -16'sd32768, 16'sd0}, 1'b0, '0});
      rows.push_back('{'{16'sd0, 16'sd0, 16'sd32767}, 1'b0, '0});
      rows.push_back('{'{-16'sd32768, -16'sd32768, -16'sd32768}, 1'b0, '0});
      rows.push_back('{'{16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, '0});
      rows.push_back('{'{16'sd32767, -16'sd32768, 16'sd32767}, 1'b0, '0});
      // near half pi and pi of the half angle
      rows.push_back('{'{16'sd12868, 16'sd0, 16'sd0}, 1'b0, '0});
      rows.push_back('{'{16'sd12867, 16'sd1, 16'sd0}, 1'b0, '0});
      rows.push_back('{'{16'sd25736, 16'sd0, 16'sd0}, 1'b0, '0});
      rows.push_back('{'{-16'sd25735, 16'sd0, 16'sd0}, 1'b0, '0});
      rows.push_back('{'{16'sd6434, 16'sd6434, 16'sd0}, 1'b0, '0});
      rows.push_back('{'{16'sd4096, 16'sd4096, 16'sd4096}, 1'b0, '0});
      // floor in the root lets a component reach theta
      rows.push_back('{'{16'sd3, 16'sd1, 16'sd1}, 1'b0, '0});
      rows.push_back('{'{16'sd100, 16'sd1, 16'sd1}, 1'b0, '0});
      rows.push_back('{'{16'sd2, 16'sd1, 16'sd0}, 1'b0, '0});
      rows.push_back('{'{-16'sd21845, 16'sd10922, -16'sd5461}, 1'b0, '0});
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (rows[i]) begin
         row = rows[i];
         send_beat(row.req, row.known ? row.rsp : exp_map(row.req));
      end
      // pause until every directed result is back
      start <= 1'b0;
      wait_count = 0;
      while (quat_queue.size() != 0 && wait_count < 4 * LATENCY) begin
         @(negedge clock);
         wait_count++;
      end
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         req_type r;
         r = rand_vec($urandom_range(3) == 0 ? $urandom_range(3) : 0);
         if ($urandom_range(1)) r = rand_vec($urandom_range(3));
         send_beat(r, exp_map(r));
         if (n < RANDOM_BEATS - 150) idle_burst(15);
      end
      start <= 1'b0;
      wait_count = 0;
      while (quat_queue.size() != 0 && wait_count < 4 * LATENCY) begin
         @(negedge clock);
         wait_count++;
      end
      if (quat_queue.size() != 0) begin
         $error("%0d results never arrived", quat_queue.size());
         error_count++;
      end
      repeat (LATENCY + 10) @(negedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
